// ===== design/masked_byte_signature_scan_assert.svh =====
// assertion macros for the masked byte signature scan checker
// expects signals clk and arst_n in the scope where a macro is used
`ifndef MASKED_BYTE_SIGNATURE_SCAN_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define MBSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbss assertion failed");

// next-cycle implication, checked while out of reset
`define MBSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbss assertion failed");

`endif

// ===== design/mbss_pkg.sv =====
// shared types and constants of the masked byte signature scan
// no dependencies
`default_nettype none

package mbss_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 6;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned ADDR_OUT = 32;
	localparam int unsigned PAT_MAX  = 32;
	localparam int unsigned CFG_AW   = 6;
	localparam int unsigned CFG_DW   = 64;
	localparam int unsigned REG_IW   = 3;

	// register indexes, byte address is 8 times the index
	localparam logic [REG_IW-1:0] REG_PAT_0_7   = 3'd0;
	localparam logic [REG_IW-1:0] REG_PAT_8_15  = 3'd1;
	localparam logic [REG_IW-1:0] REG_PAT_16_23 = 3'd2;
	localparam logic [REG_IW-1:0] REG_PAT_24_31 = 3'd3;
	localparam logic [REG_IW-1:0] REG_MASK      = 3'd4;
	localparam logic [REG_IW-1:0] REG_LENGTH    = 3'd5;
	localparam logic [REG_IW-1:0] REG_BASE      = 3'd6;

	// configuration as seen by the scan datapath
	typedef struct packed {
		logic [PAT_MAX-1:0][BYTE_W-1:0] pattern;
		logic [PAT_MAX-1:0]             mask;
		logic [LEN_W-1:0]               len_used;
		logic [ADDR_OUT-1:0]            base;
	} cfg_t;

endpackage

`default_nettype wire

// ===== design/mbss_regs.sv =====
// configuration register file with an apb-style port
// depends on mbss_pkg
`default_nettype none

module mbss_regs #(
	parameter int unsigned MAX_PATTERN = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mbss_pkg::CFG_AW-1:0] paddr,
	input  wire logic [mbss_pkg::CFG_DW-1:0] pwdata,
	output logic      [mbss_pkg::CFG_DW-1:0] prdata,
	output mbss_pkg::cfg_t                    cfg
);

	localparam logic [mbss_pkg::LEN_W-1:0] LEN_CAP = mbss_pkg::LEN_W'(MAX_PATTERN);

	logic [3:0][mbss_pkg::CFG_DW-1:0]     pat_q;
	logic [mbss_pkg::PAT_MAX-1:0]         mask_q;
	logic [mbss_pkg::LEN_W-1:0]           len_q;
	logic [mbss_pkg::ADDR_OUT-1:0]        base_q;
	logic [mbss_pkg::REG_IW-1:0]          idx;
	logic                                 wr_en;

	assign idx   = paddr[mbss_pkg::CFG_AW-1:3];
	assign wr_en = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			mask_q <= '0;
			len_q  <= mbss_pkg::LEN_W'(1);
			base_q <= '0;
		end else if (wr_en) begin
			case (idx)
				mbss_pkg::REG_PAT_0_7:   pat_q[0] <= pwdata;
				mbss_pkg::REG_PAT_8_15:  pat_q[1] <= pwdata;
				mbss_pkg::REG_PAT_16_23: pat_q[2] <= pwdata;
				mbss_pkg::REG_PAT_24_31: pat_q[3] <= pwdata;
				mbss_pkg::REG_MASK:      mask_q   <= pwdata[mbss_pkg::PAT_MAX-1:0];
				mbss_pkg::REG_LENGTH:    len_q    <= pwdata[mbss_pkg::LEN_W-1:0];
				mbss_pkg::REG_BASE:      base_q   <= pwdata[mbss_pkg::ADDR_OUT-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			mbss_pkg::REG_PAT_0_7:   prdata = pat_q[0];
			mbss_pkg::REG_PAT_8_15:  prdata = pat_q[1];
			mbss_pkg::REG_PAT_16_23: prdata = pat_q[2];
			mbss_pkg::REG_PAT_24_31: prdata = pat_q[3];
			mbss_pkg::REG_MASK:      prdata = mbss_pkg::CFG_DW'(mask_q);
			mbss_pkg::REG_LENGTH:    prdata = mbss_pkg::CFG_DW'(len_q);
			mbss_pkg::REG_BASE:      prdata = mbss_pkg::CFG_DW'(base_q);
			default:                 prdata = '0;
		endcase
	end

	// length in use: zero means one, capped at the cell count
	always_comb begin
		cfg.pattern = pat_q;
		cfg.mask    = mask_q;
		cfg.base    = base_q;
		if (len_q == '0) begin
			cfg.len_used = mbss_pkg::LEN_W'(1);
		end else if (len_q > LEN_CAP) begin
			cfg.len_used = LEN_CAP;
		end else begin
			cfg.len_used = len_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/mbss_cell.sv =====
// one window cell: holds a byte, passes it on, compares it to its pattern byte
// depends on mbss_pkg
`default_nettype none

module mbss_cell (
	input  wire logic                         clk,
	input  wire logic                         shift_en,
	input  wire logic [mbss_pkg::BYTE_W-1:0] byte_in,
	input  wire logic [mbss_pkg::BYTE_W-1:0] expect_byte,
	input  wire logic                         care,
	output logic      [mbss_pkg::BYTE_W-1:0] byte_out,
	output logic                              match
);

	logic [mbss_pkg::BYTE_W-1:0] byte_q;

	// take the neighbor's byte on every accepted transaction
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign match    = !care || (byte_q == expect_byte);

endmodule

`default_nettype wire

// ===== design/masked_byte_signature_scan.sv =====
// A byte enters stage 1 (the window cells); its result is then registered at the output.
// Throughput: one byte per cycle if not stalled; the window moves one cell per byte.
// Every window position is compared in parallel by the cells in the stage after input.
// Reset (arst_n low) clears the region byte count, the match flag, the pipeline
// and output valids, and the registers (pattern length to 1, the rest to 0).
`default_nettype none

module masked_byte_signature_scan #(
	parameter int unsigned MAX_PATTERN   = 32,
	parameter int unsigned ADDRESS_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// stream in
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
	input  wire logic                         s_axis_tlast,  // last_byte
	// stream out
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic      [31:0]                  m_axis_tdata,  // [31:0] match_address
	output logic                              m_axis_tuser,  // [0] found
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mbss_pkg::CFG_AW-1:0] paddr,
	input  wire logic [mbss_pkg::CFG_DW-1:0] pwdata,
	output logic      [mbss_pkg::CFG_DW-1:0] prdata,
	output logic                              pready
);

	localparam int unsigned AW_CUT = (ADDRESS_WIDTH >= 32) ? 32 : ADDRESS_WIDTH;
	localparam logic [mbss_pkg::ADDR_OUT-1:0] ADDR_MASK =
		{mbss_pkg::ADDR_OUT{1'b1}} >> (mbss_pkg::ADDR_OUT - AW_CUT);

	mbss_pkg::cfg_t                            cfg;
	logic                                      accept;
	logic                                      out_free;
	logic                                      valid_s1;
	logic                                      last_s1;
	logic [mbss_pkg::CNT_W-1:0]                count_s1;
	logic [mbss_pkg::CNT_W-1:0]                cnt_q;
	logic [mbss_pkg::CNT_W-1:0]                cnt_inc;
	logic                                      done_q;
	logic                                      out_valid_q;
	logic                                      found_q;
	logic [mbss_pkg::ADDR_OUT-1:0]             addr_q;
	logic [MAX_PATTERN:0][mbss_pkg::BYTE_W-1:0] chain;
	logic [MAX_PATTERN-1:0]                    cell_match;
	logic                                      hit;
	logic                                      emit;
	logic [mbss_pkg::CNT_W-1:0]                offset;
	logic [mbss_pkg::ADDR_OUT-1:0]             addr;

	assign pready = 1'b1;

	mbss_regs #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// handshake: stage 1 moves on whenever the output register can take it
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// row of window cells, newest byte in cell 0
	assign chain[0] = s_axis_tdata;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [mbss_pkg::LEN_W-1:0]  pidx;
		logic [mbss_pkg::BYTE_W-1:0] exp_byte;
		logic                        care;

		// cell j faces pattern byte len-1-j under mask bit j
		assign pidx     = cfg.len_used - mbss_pkg::LEN_W'(1) - mbss_pkg::LEN_W'(j);
		assign exp_byte = cfg.pattern[pidx[4:0]];
		assign care     = (mbss_pkg::LEN_W'(j) < cfg.len_used) && cfg.mask[j];

		mbss_cell u_cell (
			.clk         (clk),
			.shift_en    (accept),
			.byte_in     (chain[j]),
			.expect_byte (exp_byte),
			.care        (care),
			.byte_out    (chain[j+1]),
			.match       (cell_match[j])
		);
	end

	// saturating region byte count
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + mbss_pkg::CNT_W'(1);

	// stage 1 control, aligned with the window cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			count_s1 <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			last_s1  <= s_axis_tlast;
			count_s1 <= cnt_inc;
			cnt_q    <= s_axis_tlast ? '0 : cnt_inc;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// window decision and start address
	assign hit    = (count_s1 >= mbss_pkg::CNT_W'(cfg.len_used)) && (&cell_match);
	assign emit   = valid_s1 && !done_q && (hit || last_s1);
	assign offset = count_s1 - mbss_pkg::CNT_W'(cfg.len_used);
	assign addr   = (cfg.base + offset[mbss_pkg::ADDR_OUT-1:0]) & ADDR_MASK;

	// match flag: later bytes of the region, the last included, give no result; it clears at the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (valid_s1 && out_free) begin
			if (last_s1) begin
				done_q <= 1'b0;
			end else if (!done_q && hit) begin
				done_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			found_q <= hit;
			addr_q  <= hit ? addr : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = addr_q;
	assign m_axis_tuser  = found_q;

endmodule

`default_nettype wire

// ===== design/mbss_chk.sv =====
// port-level checker for the masked byte signature scan, bound to the top level
// depends on masked_byte_signature_scan_assert.svh
`default_nettype none

`include "masked_byte_signature_scan_assert.svh"

module mbss_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	logic in_xact;

	assign in_xact = s_axis_tvalid && s_axis_tready;

	// a stalled result transaction keeps its payload
	`MBSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// a not-found result carries a zero address
	`MBSS_ASSERT_NOW(a_notfound_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0)

	// an empty output never holds back the input side
	`MBSS_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

	// a new result must follow an input transaction, with stage 1 and the output register between
	`MBSS_ASSERT_NOW(a_result_cause, $rose(m_axis_tvalid), $past(in_xact, 2))

endmodule

bind masked_byte_signature_scan mbss_chk u_mbss_chk (.*);

`default_nettype wire
